>>> src/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// Types and codes shared by the sorted table and its cells.
// ----------------------------------------------------------------------------
package sti_pkg;

  // Operation codes carried in the mode field
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DELETED   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // Input item
  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
  } in_t;

  // Result item
  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         count;
    logic signed [31:0] smallest;
  } out_t;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic               ins;
    logic               del;
    logic signed [31:0] key;
  } ctrl_t;

endpackage

>>> src/sti_cell.sv
// ----------------------------------------------------------------------------
// sti_cell
// One table slot: compares its entry against the key and shifts toward or
// away from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module sti_cell (
  input  logic               clk,
  input  sti_pkg::ctrl_t     ctrl,
  input  logic               occ,
  input  logic               left_flag,
  input  logic signed [31:0] left_ent,
  input  logic signed [31:0] right_ent,
  output logic               ins_flag,
  output logic               match,
  output logic signed [31:0] ent,
  output logic signed [31:0] ent_nxt
);

  logic signed [31:0] ent_r;
  logic               del_flag;

  // Mark cells at or past the insert point (first entry greater than key)
  // and at or past the delete point (first entry not smaller than key)
  assign ins_flag = !occ || (ent_r > ctrl.key);
  assign del_flag = !occ || (ent_r >= ctrl.key);
  assign match    = occ && (ent_r == ctrl.key);

  // Take the key, shift right from the left neighbor, or pull from the right
  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins && ins_flag) begin
      ent_nxt = left_flag ? left_ent : ctrl.key;
    end else if (ctrl.del && del_flag) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

>>> src/sorted_table_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_delete
// Bounded table of signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_item and raise start; the item is taken at the
//   edge where start is high and busy is low. busy stays low, so an item
//   can be given every cycle.
//   mode insert places the value after all stored values not greater than
//   it; mode delete removes the first stored value equal to the key.
//   Result channel: out_valid pulses for one cycle, in the cycle after the
//   item is taken, with status, the new count and the smallest value
//   (zero when the table is empty). The receiver cannot stall.
//   Throughput is 1 item per cycle: every cell compares
//   its entry to the key in parallel and shifts in the same cycle, so the
//   compare plus the neighbor shift through the row sets the clock.
//   Reset empties the table (count zero); entry contents are not cleared
//   and are never read above the count.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sti_pkg::in_t  in_item,
  output logic          out_valid,
  output sti_pkg::out_t out_item
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic               out_valid_r;
  sti_pkg::out_t      out_item_r;
  sti_pkg::out_t      out_item_nxt;
  sti_pkg::ctrl_t     ctrl;

  logic [DEPTH-1:0]   ins_flag;
  logic [DEPTH-1:0]   match;
  logic signed [31:0] ent     [DEPTH];
  logic signed [31:0] ent_nxt [DEPTH];

  logic               accept;
  logic               full;
  logic               empty;
  logic               found;
  logic [CW+4:0]      count_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign found  = |match;

  // Broadcast the operation to the row of cells
  assign ctrl.key = in_item.value;
  assign ctrl.ins = accept && (in_item.mode == sti_pkg::MODE_INSERT) && !full;
  assign ctrl.del = accept && (in_item.mode == sti_pkg::MODE_DELETE) && found;

  // Build the row; each cell sees its neighbors' entries and its left neighbor's flag
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               left_flag;
    logic signed [31:0] left_ent;
    logic signed [31:0] right_ent;

    if (i == 0) begin : g_first
      assign left_flag = 1'b0;
      assign left_ent  = ent[0];
    end else begin : g_mid
      assign left_flag = ins_flag[i-1];
      assign left_ent  = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_nlast
      assign right_ent = ent[i+1];
    end

    sti_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (CW'(i) < count_r),
      .left_flag (left_flag),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ins_flag  (ins_flag[i]),
      .match     (match[i]),
      .ent       (ent[i]),
      .ent_nxt   (ent_nxt[i])
    );
  end

  // Update the count and form the result
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign count_ext = {5'd0, count_nxt};

  always_comb begin
    out_item_nxt.count    = count_ext[4:0];
    out_item_nxt.smallest = (count_nxt != '0) ? ent_nxt[0] : 32'sd0;
    if (in_item.mode == sti_pkg::MODE_INSERT) begin
      out_item_nxt.status = full ? sti_pkg::ST_FULL : sti_pkg::ST_INSERTED;
    end else if (empty) begin
      out_item_nxt.status = sti_pkg::ST_EMPTY;
    end else if (found) begin
      out_item_nxt.status = sti_pkg::ST_DELETED;
    end else begin
      out_item_nxt.status = sti_pkg::ST_NOT_FOUND;
    end
  end

  // Hold control state; clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Capture the result payload with each item
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> src/sti_checker.sv
// ----------------------------------------------------------------------------
// sti_checker
// Port-level checks on the sorted table's result strobe and fields.
// ----------------------------------------------------------------------------
module sti_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input sti_pkg::out_t out_item,
  input logic          out_valid
);

  // One result for every item taken, in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("item taken without a result");

  // No result without an item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an item");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status <= sti_pkg::ST_FULL))
    else $error("undefined status code");

  // An empty table reports zero as smallest
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.count == 5'd0)) |-> (out_item.smallest == 32'sd0))
    else $error("empty table with nonzero smallest");

endmodule

bind sorted_table_insert_delete sti_checker u_sti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_item  (out_item),
  .out_valid (out_valid)
);
